FILE: hdl/rpdr_pkg.sv
// ----------------------------------------------------------------------------
// rpdr_pkg
// Shared types and constants for the ray / plane, disc and ring intersector.
// ----------------------------------------------------------------------------
package rpdr_pkg;

	localparam int CoordW   = 32;
	localparam int RadW     = 31;
	localparam int NumW     = 67;              // sum of three 65-bit products
	localparam int DenW     = 66;              // sum of three 64-bit products
	localparam int RemW     = NumW + 16;       // |num| scaled by 2^16
	localparam int QW       = 32;
	localparam int CmpW     = DenW + QW;       // divisor shifted by up to 31, plus a carry
	localparam int IdxW     = 4;

	localparam logic [1:0] KIND_PLANE = 2'd0;
	localparam logic [1:0] KIND_DISC  = 2'd1;
	localparam logic [1:0] KIND_RING  = 2'd2;

	localparam logic [IdxW-1:0] REG_CENTER_X     = 4'd0;
	localparam logic [IdxW-1:0] REG_CENTER_Y     = 4'd1;
	localparam logic [IdxW-1:0] REG_CENTER_Z     = 4'd2;
	localparam logic [IdxW-1:0] REG_NORMAL_X     = 4'd3;
	localparam logic [IdxW-1:0] REG_NORMAL_Y     = 4'd4;
	localparam logic [IdxW-1:0] REG_NORMAL_Z     = 4'd5;
	localparam logic [IdxW-1:0] REG_INNER_RADIUS = 4'd6;
	localparam logic [IdxW-1:0] REG_OUTER_RADIUS = 4'd7;

	localparam logic signed [CoordW-1:0] NORMAL_Y_RST = 32'sd65536;
	localparam logic [RadW-1:0]          OUTER_RST    = 31'd65536;

	localparam logic signed [QW-1:0] T_MAX = 32'sh7fff_ffff;
	localparam logic signed [QW-1:0] T_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [CoordW-1:0] ox;
		logic signed [CoordW-1:0] oy;
		logic signed [CoordW-1:0] oz;
		logic signed [CoordW-1:0] dx;
		logic signed [CoordW-1:0] dy;
		logic signed [CoordW-1:0] dz;
	} ray_t;

	typedef struct packed {
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic signed [CoordW-1:0] cz;
		logic signed [CoordW-1:0] nx;
		logic signed [CoordW-1:0] ny;
		logic signed [CoordW-1:0] nz;
		logic [RadW-1:0]          inner;
		logic [RadW-1:0]          outer;
	} target_t;

endpackage

FILE: hdl/rpdr_dot.sv
// ----------------------------------------------------------------------------
// rpdr_dot
// Two stages: six signed products, then the numerator and denominator sums.
// ----------------------------------------------------------------------------
module rpdr_dot (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  rpdr_pkg::ray_t        ray,
	input  rpdr_pkg::target_t     tgt,
	output logic                  v_s2,
	output logic signed [66:0]    num_s2,
	output logic signed [65:0]    den_s2,
	output rpdr_pkg::ray_t        ray_s2
);
	import rpdr_pkg::*;

	logic signed [CoordW-1:0] o [3];
	logic signed [CoordW-1:0] d [3];
	logic signed [CoordW-1:0] c [3];
	logic signed [CoordW-1:0] n [3];
	logic signed [CoordW:0]   diff [3];
	logic signed [64:0]       pn_c [3];
	logic signed [63:0]       pd_c [3];

	logic signed [64:0]       pn_s1 [3];
	logic signed [63:0]       pd_s1 [3];
	logic                     v_s1;
	ray_t                     ray_s1;

	always_comb begin
		o = '{ray.ox, ray.oy, ray.oz};
		d = '{ray.dx, ray.dy, ray.dz};
		c = '{tgt.cx, tgt.cy, tgt.cz};
		n = '{tgt.nx, tgt.ny, tgt.nz};
		for (int i = 0; i < 3; i++) begin
			diff[i] = 33'(c[i]) - 33'(o[i]);
			pn_c[i] = 65'(diff[i]) * 65'(n[i]);
			pd_c[i] = 64'(d[i]) * 64'(n[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pn_s1  <= pn_c;
			pd_s1  <= pd_c;
			ray_s1 <= ray;
			num_s2 <= 67'(pn_s1[0]) + 67'(pn_s1[1]) + 67'(pn_s1[2]);
			den_s2 <= 66'(pd_s1[0]) + 66'(pd_s1[1]) + 66'(pd_s1[2]);
			ray_s2 <= ray_s1;
		end
	end

endmodule

FILE: hdl/rpdr_div.sv
// ----------------------------------------------------------------------------
// rpdr_div
// Pipelined restoring divider: t = trunc(num * 2^16 / den), saturated.
// Sign and range check take two stages, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rpdr_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  logic signed [66:0]    num,
	input  logic signed [65:0]    den,
	input  rpdr_pkg::ray_t        ray_in,
	output logic                  v_out,
	output logic signed [31:0]    t_out,
	output logic                  ovf_out,
	output rpdr_pkg::ray_t        ray_out
);
	import rpdr_pkg::*;

	// sign / magnitude stage
	logic               v_s3, neg_s3, zero_s3;
	logic [NumW-1:0]    anum_s3;
	logic [DenW-1:0]    dv_s3;
	ray_t               ray_s3;

	// per-bit stages, index 0 is the range check output
	logic               v_s   [QW+1];
	logic               neg_s [QW+1];
	logic               skip_s[QW+1];
	logic               ovf_s [QW+1];
	logic [RemW-1:0]    rem_s [QW+1];
	logic [DenW-1:0]    dv_s  [QW+1];
	logic [QW-1:0]      q_s   [QW+1];
	ray_t               ray_s [QW+1];

	logic [CmpW-1:0]    lim;
	logic               ovf_c;

	always_comb begin
		lim   = ({{QW{1'b0}}, dv_s3} << 31) + (neg_s3 ? {{QW{1'b0}}, dv_s3} : '0);
		ovf_c = !zero_s3 && ({{(CmpW-RemW){1'b0}}, anum_s3, 16'b0} >= lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s3   <= v_in;
			v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3   <= num[NumW-1] ^ den[DenW-1];
			zero_s3  <= (den == '0);
			anum_s3  <= num[NumW-1] ? NumW'(-num) : NumW'(num);
			dv_s3    <= den[DenW-1] ? DenW'(-den) : DenW'(den);
			ray_s3   <= ray_in;
			neg_s[0] <= neg_s3;
			skip_s[0]<= zero_s3 | ovf_c;
			ovf_s[0] <= ovf_c;
			rem_s[0] <= {anum_s3, 16'b0};
			dv_s[0]  <= dv_s3;
			q_s[0]   <= '0;
			ray_s[0] <= ray_s3;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_bit
		localparam int B = QW - 1 - k;
		logic [CmpW-1:0] sh;
		logic            ge;

		always_comb begin
			sh = {{QW{1'b0}}, dv_s[k]} << B;
			ge = ({{(CmpW-RemW){1'b0}}, rem_s[k]} >= sh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1]  <= neg_s[k];
				skip_s[k+1] <= skip_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				dv_s[k+1]   <= dv_s[k];
				ray_s[k+1]  <= ray_s[k];
				rem_s[k+1]  <= ge ? rem_s[k] - sh[RemW-1:0] : rem_s[k];
				q_s[k+1]    <= q_s[k] | (QW'(ge) << B);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_out <= ovf_s[QW];
			ray_out <= ray_s[QW];
			priority if (ovf_s[QW]) begin
				t_out <= neg_s[QW] ? T_MIN : T_MAX;
			end else if (skip_s[QW]) begin
				t_out <= '0;
			end else begin
				t_out <= neg_s[QW] ? -$signed(q_s[QW]) : $signed(q_s[QW]);
			end
		end
	end

endmodule

FILE: hdl/rpdr_check.sv
// ----------------------------------------------------------------------------
// rpdr_check
// Disc and ring radius test on the hit point; the last stage is the output
// register.
// ----------------------------------------------------------------------------
module rpdr_check (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  logic signed [31:0]    t_in,
	input  logic                  ovf_in,
	input  rpdr_pkg::ray_t        ray,
	input  rpdr_pkg::target_t     tgt,
	output logic                  v_out,
	output logic signed [31:0]    t_out,
	output logic                  ovf_out
);
	import rpdr_pkg::*;

	logic signed [CoordW-1:0] o [3];
	logic signed [CoordW-1:0] d [3];
	logic signed [CoordW-1:0] c [3];
	logic signed [CoordW:0]   diff [3];
	logic signed [63:0]       delta_c [3];
	logic [63:0]              mag [3];

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [QW-1:0]     t_s1, t_s2, t_s3, t_s4;
	logic                     ovf_s1, ovf_s2, ovf_s3, ovf_s4;
	logic [1:0]               kind_s1, kind_s2, kind_s3, kind_s4;
	logic signed [63:0]       delta_s1 [3];
	logic [61:0]              out2_s1, out2_s2, out2_s3, out2_s4;
	logic [61:0]              in2_s1, in2_s2, in2_s3, in2_s4;
	logic [63:0]              hh_s2 [3];
	logic [63:0]              hl_s2 [3];
	logic [63:0]              ll_s2 [3];
	logic [127:0]             sq_s3 [3];
	logic [127:0]             dist_s4;

	logic                     far, near, miss;

	always_comb begin
		o = '{ray.ox, ray.oy, ray.oz};
		d = '{ray.dx, ray.dy, ray.dz};
		c = '{tgt.cx, tgt.cy, tgt.cz};
		for (int i = 0; i < 3; i++) begin
			diff[i]    = 33'(o[i]) - 33'(c[i]);
			delta_c[i] = (64'(diff[i]) <<< 16) + 64'(d[i]) * 64'(t_in);
			mag[i]     = delta_s1[i][63] ? 64'(-delta_s1[i]) : 64'(delta_s1[i]);
		end
		far  = dist_s4 > {34'b0, out2_s4, 32'b0};
		near = dist_s4 < {34'b0, in2_s4, 32'b0};
		miss = (t_s4 != '0) &&
			(((kind_s4 == KIND_DISC) && far) || ((kind_s4 == KIND_RING) && (far || near)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_out <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// hit offset and squared radii
			delta_s1 <= delta_c;
			out2_s1  <= 62'(tgt.outer) * 62'(tgt.outer);
			in2_s1   <= 62'(tgt.inner) * 62'(tgt.inner);
			t_s1     <= t_in;
			ovf_s1   <= ovf_in;
			kind_s1  <= ray.kind;
			// partial squares of each magnitude
			for (int i = 0; i < 3; i++) begin
				hh_s2[i] <= 64'(mag[i][63:32]) * 64'(mag[i][63:32]);
				hl_s2[i] <= 64'(mag[i][63:32]) * 64'(mag[i][31:0]);
				ll_s2[i] <= 64'(mag[i][31:0]) * 64'(mag[i][31:0]);
			end
			{t_s2, ovf_s2, kind_s2, out2_s2, in2_s2} <= {t_s1, ovf_s1, kind_s1, out2_s1, in2_s1};
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= {hh_s2[i], 64'b0} + {31'b0, hl_s2[i], 33'b0} + {64'b0, ll_s2[i]};
			end
			{t_s3, ovf_s3, kind_s3, out2_s3, in2_s3} <= {t_s2, ovf_s2, kind_s2, out2_s2, in2_s2};
			dist_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			{t_s4, ovf_s4, kind_s4, out2_s4, in2_s4} <= {t_s3, ovf_s3, kind_s3, out2_s3, in2_s3};
			t_out   <= miss ? '0 : t_s4;
			ovf_out <= ovf_s4;
		end
	end

endmodule

FILE: hdl/ray_plane_disc_ring_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_plane_disc_ring_intersect_top
// Ray against a plane, disc or ring held in configuration registers. Returns
// the signed Q16.16 ray parameter t (0 = no hit) and a saturation flag.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | word
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_stall  | kind, origin_x/y/z, dir_x/y/z
//  output   | out_valid / out_stall| hit_distance, overflow
//  config   | cfg_valid / cfg_ready| cfg_index (0..7), cfg_data
//
//  One ray enters per cycle while the output is not stalled. The pipe has
//  2 dot-product stages, 35 divider stages (sign, range check, 32 quotient
//  bits and the result) and 5 radius-check stages ending in the output
//  register. The 32-step divider sets the depth.
//  Reset clears all valid bits and loads the target defaults (normal along
//  +y, outer radius 1.0). A stalled output word freezes the whole pipeline,
//  so in_stall follows out_stall while the output register holds a word.
//  Config writes are always taken and must occur only when the pipe is empty.
// ----------------------------------------------------------------------------
module ray_plane_disc_ring_intersect_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic signed [rpdr_pkg::CoordW-1:0]   origin_x,
	input  logic signed [rpdr_pkg::CoordW-1:0]   origin_y,
	input  logic signed [rpdr_pkg::CoordW-1:0]   origin_z,
	input  logic signed [rpdr_pkg::CoordW-1:0]   dir_x,
	input  logic signed [rpdr_pkg::CoordW-1:0]   dir_y,
	input  logic signed [rpdr_pkg::CoordW-1:0]   dir_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [rpdr_pkg::QW-1:0]       hit_distance,
	output logic                                 overflow,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rpdr_pkg::IdxW-1:0]            cfg_index,
	input  logic [rpdr_pkg::CoordW-1:0]          cfg_data
);
	import rpdr_pkg::*;

	target_t            tgt_q;
	ray_t               ray_in;
	logic               en;

	logic               v_dot;
	logic signed [66:0] num_dot;
	logic signed [65:0] den_dot;
	ray_t               ray_dot;

	logic               v_div;
	logic signed [31:0] t_div;
	logic               ovf_div;
	ray_t               ray_div;

	// advance the whole pipe unless the output word is held
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	assign ray_in = '{kind: kind, ox: origin_x, oy: origin_y, oz: origin_z,
		dx: dir_x, dy: dir_y, dz: dir_z};

	// target registers; writes beyond the list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= '{cx: '0, cy: '0, cz: '0, nx: '0, ny: NORMAL_Y_RST, nz: '0,
				inner: '0, outer: OUTER_RST};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_X:     tgt_q.cx    <= cfg_data;
				REG_CENTER_Y:     tgt_q.cy    <= cfg_data;
				REG_CENTER_Z:     tgt_q.cz    <= cfg_data;
				REG_NORMAL_X:     tgt_q.nx    <= cfg_data;
				REG_NORMAL_Y:     tgt_q.ny    <= cfg_data;
				REG_NORMAL_Z:     tgt_q.nz    <= cfg_data;
				REG_INNER_RADIUS: tgt_q.inner <= cfg_data[RadW-1:0];
				REG_OUTER_RADIUS: tgt_q.outer <= cfg_data[RadW-1:0];
				default: ;
			endcase
		end
	end

	// numerator dot(C - O, N) and denominator dot(D, N)
	rpdr_dot u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (in_valid),
		.ray    (ray_in),
		.tgt    (tgt_q),
		.v_s2   (v_dot),
		.num_s2 (num_dot),
		.den_s2 (den_dot),
		.ray_s2 (ray_dot)
	);

	// quotient with zero-denominator and saturation handling
	rpdr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_dot),
		.num     (num_dot),
		.den     (den_dot),
		.ray_in  (ray_dot),
		.v_out   (v_div),
		.t_out   (t_div),
		.ovf_out (ovf_div),
		.ray_out (ray_div)
	);

	// disc / ring radius test and output register
	rpdr_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_div),
		.t_in    (t_div),
		.ovf_in  (ovf_div),
		.ray     (ray_div),
		.tgt     (tgt_q),
		.v_out   (out_valid),
		.t_out   (hit_distance),
		.ovf_out (overflow)
	);

endmodule

FILE: hdl/rpdr_chk.sv
// ----------------------------------------------------------------------------
// rpdr_chk
// Port-level checks for the intersector, bound to the top level.
// ----------------------------------------------------------------------------
module rpdr_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [rpdr_pkg::QW-1:0]       hit_distance,
	input logic                                 overflow
);
	import rpdr_pkg::*;

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit_distance) && $stable(overflow))
		else $error("stalled output word changed");

	// input stalls only behind a held output word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// saturated t is either limit or a forced miss
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			hit_distance == T_MAX || hit_distance == T_MIN || hit_distance == '0)
		else $error("overflow with unsaturated t");

	// no word appears right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid straight out of reset");

endmodule

bind ray_plane_disc_ring_intersect_top rpdr_chk u_rpdr_chk (.*);

FILE: dv/tb_ray_plane_disc_ring_intersect_top.sv
// ----------------------------------------------------------------------------
// tb_ray_plane_disc_ring_intersect_top
// Streams rays in and predicts each word not set by a directed row with an
// exact wide integer model of t = dot(C - O, N) / dot(D, N), saturation and
// the disc and ring radius checks; compares every output word in order.
// Target registers are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_plane_disc_ring_intersect_top;
	import rpdr_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int PIPE_DEPTH  = 42;
	localparam int STALL_LIMIT = 4000;
	localparam int NUM_PHASES  = 9;
	localparam int RAYS_PER_PH = 90;

	// predicted output word
	typedef struct packed {
		logic signed [QW-1:0] t;
		logic                 ovf;
	} hit_t;

	// directed row: ray plus an optional hand-written answer
	typedef struct packed {
		logic       typed;
		ray_t       ray;
		hit_t       want;
	} row_t;

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] TWO = 32'h0002_0000;

	// all rows run with the reset target: centre 0, normal +y, outer 1.0
	localparam int NUM_ROWS = 14;
	localparam row_t ROWS [NUM_ROWS] = '{
		// plain plane hit at t = 2.0
		'{1'b1, '{KIND_PLANE, 32'd0, TWO, 32'd0, 32'd0, -ONE, 32'd0}, '{TWO, 1'b0}},
		// direction parallel to the plane: zero denominator
		'{1'b1, '{KIND_PLANE, 32'd0, TWO, 32'd0, ONE, 32'd0, 32'd0}, '{32'd0, 1'b0}},
		// all-zero ray
		'{1'b1, '{KIND_PLANE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, '{32'd0, 1'b0}},
		// saturate high
		'{1'b1, '{KIND_PLANE, 32'd0, 32'h7fff_0000, 32'd0, 32'd0, 32'hffff_ffff, 32'd0},
			'{T_MAX, 1'b1}},
		// saturate low
		'{1'b1, '{KIND_PLANE, 32'd0, 32'h7fff_0000, 32'd0, 32'd0, 32'd1, 32'd0},
			'{T_MIN, 1'b1}},
		// saturated disc hit lands far away: forced miss keeps the flag
		'{1'b1, '{KIND_DISC, 32'd0, 32'h7fff_0000, 32'd0, 32'd0, 32'hffff_ffff, 32'd0},
			'{32'd0, 1'b1}},
		// disc hit at the centre
		'{1'b1, '{KIND_DISC, 32'd0, TWO, 32'd0, 32'd0, -ONE, 32'd0}, '{TWO, 1'b0}},
		// ring hit with inner radius 0
		'{1'b1, '{KIND_RING, 32'd0, TWO, 32'd0, 32'd0, -ONE, 32'd0}, '{TWO, 1'b0}},
		// unused kind behaves as a plane
		'{1'b1, '{2'd3, TWO, TWO, 32'd0, 32'd0, -ONE, 32'd0}, '{TWO, 1'b0}},
		// disc miss, hit point at x = 2.0
		'{1'b1, '{KIND_DISC, TWO, TWO, 32'd0, 32'd0, -ONE, 32'd0}, '{32'd0, 1'b0}},
		// hit point exactly on the rim still counts
		'{1'b1, '{KIND_DISC, ONE, TWO, 32'd0, 32'd0, -ONE, 32'd0}, '{TWO, 1'b0}},
		// negative t, disc hit behind the origin
		'{1'b1, '{KIND_DISC, 32'd0, -TWO, 32'd0, 32'd0, -ONE, 32'd0},
			'{32'hfffe_0000, 1'b0}},
		// field extremes, left to the predictor
		'{1'b0, '{KIND_PLANE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, '{32'd0, 1'b0}},
		'{1'b0, '{KIND_RING, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '{32'd0, 1'b0}}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               kind;
	logic signed [CoordW-1:0] origin_x, origin_y, origin_z;
	logic signed [CoordW-1:0] dir_x, dir_y, dir_z;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [QW-1:0]     hit_distance;
	logic                     overflow;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [IdxW-1:0]          cfg_index;
	logic [CoordW-1:0]        cfg_data;

	target_t target;           // shadow copy of the target registers
	hit_t    pending_hits[$];  // words still owed by the pipe
	int      errors;
	int      idle_cycles;
	int      gap_pct;          // chance per slot that the ray source holds off
	int      stall_pct;        // chance per cycle that the sink stalls

	ray_plane_disc_ring_intersect_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.origin_z    (origin_z),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.dir_z       (dir_z),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit_distance(hit_distance),
		.overflow    (overflow),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Exact intersection: every product and sum held at 130 bits, so nothing
	// wraps; division on signed operands truncates toward zero.
	function automatic hit_t intersect_ray(ray_t r, target_t g);
		logic signed [129:0] o [3];
		logic signed [129:0] d [3];
		logic signed [129:0] c [3];
		logic signed [129:0] n [3];
		logic signed [129:0] num, den, q, delta, dist_sq, r_in, r_out;
		hit_t h;
		o[0] = $signed(r.ox); o[1] = $signed(r.oy); o[2] = $signed(r.oz);
		d[0] = $signed(r.dx); d[1] = $signed(r.dy); d[2] = $signed(r.dz);
		c[0] = $signed(g.cx); c[1] = $signed(g.cy); c[2] = $signed(g.cz);
		n[0] = $signed(g.nx); n[1] = $signed(g.ny); n[2] = $signed(g.nz);
		r_in  = g.inner;
		r_out = g.outer;
		num = 0;
		den = 0;
		for (int i = 0; i < 3; i++) begin
			num = num + (c[i] - o[i]) * n[i];
			den = den + d[i] * n[i];
		end
		q = 0;
		h.ovf = 1'b0;
		if (den != 0) begin
			q = (num * 65536) / den;
			if (q > 64'sd2147483647) begin
				q = 64'sd2147483647;
				h.ovf = 1'b1;
			end else if (q < -64'sd2147483648) begin
				q = -64'sd2147483648;
				h.ovf = 1'b1;
			end
		end
		if (q != 0 && (r.kind == KIND_DISC || r.kind == KIND_RING)) begin
			dist_sq = 0;
			for (int i = 0; i < 3; i++) begin
				delta   = (o[i] - c[i]) * 65536 + d[i] * q;
				dist_sq = dist_sq + delta * delta;
			end
			if (dist_sq > ((r_out * r_out) <<< 32))
				q = 0;
			else if (r.kind == KIND_RING && dist_sq < ((r_in * r_in) <<< 32))
				q = 0;
		end
		h.t = q[31:0];
		return h;
	endfunction

	// small signed value in [-2^bits, 2^bits]
	function automatic logic [31:0] near_zero(int bits);
		return 32'($urandom_range(0, 2 ** (bits + 1))) - 32'(2 ** bits);
	endfunction

	// coordinate that often sits on an extreme
	function automatic logic [31:0] any_coord();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3: return near_zero(20);
			default: return $urandom;
		endcase
	endfunction

	// Aimed ray: pick a point near the centre, step back k direction units.
	// Otherwise a noise ray with arbitrary fields.
	function automatic ray_t random_ray();
		ray_t        r;
		logic [31:0] p [3];
		logic [31:0] dv [3];
		int          k;
		r.kind = 2'($urandom_range(3));
		if ($urandom_range(99) < 70) begin
			k = $urandom_range(1, 12);
			for (int i = 0; i < 3; i++) begin
				p[i]  = near_zero(18);
				dv[i] = near_zero(17);
			end
			r.dx = dv[0];
			r.dy = dv[1];
			r.dz = dv[2];
			r.ox = target.cx + p[0] - dv[0] * k;
			r.oy = target.cy + p[1] - dv[1] * k;
			r.oz = target.cz + p[2] - dv[2] * k;
			if ($urandom_range(9) == 0)
				r.kind = KIND_DISC;
		end else begin
			r.ox = any_coord();
			r.oy = any_coord();
			r.oz = any_coord();
			r.dx = any_coord();
			r.dy = any_coord();
			r.dz = any_coord();
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
		errors++;
	endtask

	// Present one ray, hold it until taken, then record the owed word.
	// Leave in_valid high so back-to-back rays need no extra edge.
	task automatic send_ray(input ray_t r, input logic typed, input hit_t want);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= r.kind;
		origin_x <= r.ox;
		origin_y <= r.oy;
		origin_z <= r.oz;
		dir_x    <= r.dx;
		dir_y    <= r.dy;
		dir_z    <= r.dz;
		do @(posedge clk); while (in_stall);
		pending_hits.push_back(typed ? want : intersect_ray(r, target));
	endtask

	// Write one register; leave cfg_valid high for the caller to drop.
	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CENTER_X:     target.cx = value;
			REG_CENTER_Y:     target.cy = value;
			REG_CENTER_Z:     target.cz = value;
			REG_NORMAL_X:     target.nx = value;
			REG_NORMAL_Y:     target.ny = value;
			REG_NORMAL_Z:     target.nz = value;
			REG_INNER_RADIUS: target.inner = value[RadW-1:0];
			REG_OUTER_RADIUS: target.outer = value[RadW-1:0];
			default: ;
		endcase
	endtask

	// Hold the source until every owed word is out, then let the pipe flush.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	// Load a target for one phase; early phases hit the corners.
	task automatic load_target(input int phase);
		logic [31:0] v [8];
		int          axis;
		for (int i = 0; i < 3; i++) begin
			v[i]     = near_zero(20);
			v[3 + i] = near_zero(17);
		end
		v[6] = 32'($urandom_range(0, 2 ** 17));
		v[7] = 32'($urandom_range(2 ** 16, 2 ** 19));
		if ($urandom_range(1)) begin
			axis = $urandom_range(2);
			for (int i = 0; i < 3; i++)
				v[3 + i] = (i == axis) ? ONE : 32'd0;
		end
		case (phase)
			1: v = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
				32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
			2: v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0};
			3: begin
				v[3] = 32'd0;  // zero normal: every ray is parallel
				v[4] = 32'd0;
				v[5] = 32'd0;
			end
			4: v[6] = v[7] + 32'd1;  // inner above outer: a ring never hits
			default: ;
		endcase
		for (int i = 0; i < 8; i++)
			write_reg(IdxW'(i), v[i]);
		// stray indexes beyond the register file must be ignored
		write_reg(4'd8, $urandom);
		write_reg(4'd15, $urandom);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Output side: random stall, checked against the oldest owed word.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				report_mismatch("unexpected word", hit_distance, 32'd0);
			end else begin
				if (hit_distance !== pending_hits[0].t)
					report_mismatch("hit_distance", hit_distance, pending_hits[0].t);
				if (overflow !== pending_hits[0].ovf)
					report_mismatch("overflow", 32'(overflow), 32'(pending_hits[0].ovf));
				void'(pending_hits.pop_front());
			end
		end
	end

	// Watchdog: count cycles in which no channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[%0t] watchdog: no progress", $realtime);
			$display("** ray_plane_disc_ring_intersect_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		ray_t r;
		hit_t none;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		kind        = '0;
		origin_x    = '0;
		origin_y    = '0;
		origin_z    = '0;
		dir_x       = '0;
		dir_y       = '0;
		dir_z       = '0;
		out_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		errors      = 0;
		idle_cycles = 0;
		gap_pct     = 24;
		stall_pct   = 84;
		none        = '0;
		target      = '{32'd0, 32'd0, 32'd0, 32'd0, NORMAL_Y_RST, 32'd0, 31'd0, OUTER_RST};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows against the reset target
		for (int i = 0; i < NUM_ROWS; i++)
			send_ray(ROWS[i].ray, ROWS[i].typed, ROWS[i].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_pipe();
			load_target(ph);
			// sender idles lightly first, then heavily, then not at all
			if (ph < 3) begin
				gap_pct   = 24;
				stall_pct = 84;
			end else if (ph < 6) begin
				gap_pct   = 84;
				stall_pct = 24;
			end else begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			for (int n = 0; n < RAYS_PER_PH; n++) begin
				// hold off mid-phase until the pipe has returned everything
				if (ph == 4 && n == RAYS_PER_PH / 2) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pending_hits.size() != 0);
				end
				r = random_ray();
				send_ray(r, 1'b0, none);
			end
		end

		drain_pipe();
		if (errors == 0)
			$display("** ray_plane_disc_ring_intersect_top: PASSED **");
		else
			$display("** ray_plane_disc_ring_intersect_top: FAILED **");
		$finish;
	end

endmodule
